@@ src/fr_pkg.sv @@
// Shared definitions for the fraction reducer: data width, status codes,
// the control word format and the microcode table of the sequencer.
// No dependencies.
package fr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int STEP_W     = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_MOST_NEG = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PAIR,
        OP_GSTEP,
        OP_GFIN,
        OP_DIVSTEP,
        OP_SAVEN,
        OP_SAVED,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOVALID,
        C_SPECIAL,
        C_BOTHEVEN,
        C_ANZ,
        C_CNTNZ,
        C_OUTBUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam logic [STEP_W-1:0] S_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_PAIR  = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_GCD   = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_DIVN  = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_DIVD  = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_EMIT  = STEP_W'(9);

    // The program: one control word per step. A word jumps to its target
    // when its condition holds and otherwise goes on to the next step.
    function automatic ctrl_t fr_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            4'd0:    w = '{OP_LOAD,    C_NOVALID,  S_IDLE};
            4'd1:    w = '{OP_NONE,    C_SPECIAL,  S_EMIT};
            4'd2:    w = '{OP_PAIR,    C_BOTHEVEN, S_PAIR};
            4'd3:    w = '{OP_GSTEP,   C_ANZ,      S_GCD};
            4'd4:    w = '{OP_GFIN,    C_NEVER,    S_IDLE};
            4'd5:    w = '{OP_DIVSTEP, C_CNTNZ,    S_DIVN};
            4'd6:    w = '{OP_SAVEN,   C_NEVER,    S_IDLE};
            4'd7:    w = '{OP_DIVSTEP, C_CNTNZ,    S_DIVD};
            4'd8:    w = '{OP_SAVED,   C_NEVER,    S_IDLE};
            4'd9:    w = '{OP_EMIT,    C_OUTBUSY,  S_EMIT};
            default: w = '{OP_NONE,    C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/fr_if.sv @@
// Valid/ready channels of the fraction reducer: the fraction item in and
// the reduced fraction item out. Depends on fr_pkg.
interface fr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fr_pkg::DATA_WIDTH-1:0] numerator;
    logic signed [fr_pkg::DATA_WIDTH-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface fr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fr_pkg::DATA_WIDTH-1:0] reduced_numerator;
    logic signed [fr_pkg::DATA_WIDTH-1:0] reduced_denominator;
    logic        [1:0]                     status;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output status, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input status, output ready);
endinterface

@@ src/fraction_reducer.sv @@
// Fraction reducer: a microcoded sequencer over a binary GCD and a restoring divider.
// Sequence: a zero or out-of-range operand goes from the load step straight to the emit step;
// any other is paired down by shared factors of two, run through the GCD, then divided twice.
// Flow: one item at a time; the next is taken at the load step once the result reaches the
// output register, which holds it while that item is worked on; a held result stalls.
// Reset: rst_n, asynchronous and active low, restarts the program and empties the output.
module fraction_reducer (
    input  logic      clk,
    input  logic      rst_n,
    fr_in_if.sink     req,
    fr_out_if.source  res
);

    localparam int W = fr_pkg::DATA_WIDTH;

    // Sequencer: the step counter addresses the microcode table.
    logic [fr_pkg::STEP_W-1:0] step_reg, step_next;
    fr_pkg::ctrl_t             ctrl;

    // Datapath registers.
    logic [W-1:0]             a_reg, a_next;     // GCD working operand
    logic [W-1:0]             b_reg, b_next;     // GCD working operand
    logic [W-1:0]             an_reg, an_next;   // |numerator|
    logic [W-1:0]             ad_reg, ad_next;   // |denominator|
    logic [W-1:0]             g_reg, g_next;     // the GCD once found
    logic [W-1:0]             rem_reg, rem_next; // divider remainder
    logic [W-1:0]             quo_reg, quo_next; // divider quotient / dividend
    logic [fr_pkg::CNT_W-1:0] k_reg, k_next;     // common power of two
    logic [fr_pkg::CNT_W-1:0] cnt_reg, cnt_next; // divider bit counter
    logic                     neg_reg, neg_next;
    logic                     spec_reg, spec_next;
    logic [W-1:0]             rn_reg, rn_next;
    logic [W-1:0]             rd_reg, rd_next;
    logic [1:0]               st_reg, st_next;

    // Output register, which parts the result side from the sequencer.
    logic                     ovalid_reg, ovalid_next;
    logic [W-1:0]             onum_reg, onum_next;
    logic [W-1:0]             oden_reg, oden_next;
    logic [1:0]               ost_reg, ost_next;

    logic [W-1:0] most_neg;
    logic [W-1:0] num_in, den_in;
    logic [W:0]   diff_ab;
    logic [W-1:0] diff_ba;
    logic [W:0]   trial;
    logic         out_busy;
    logic         cond_hit;

    assign ctrl     = fr_pkg::fr_rom(step_reg);
    assign most_neg = {1'b1, {(W-1){1'b0}}};
    assign num_in   = req.numerator;
    assign den_in   = req.denominator;
    assign diff_ab  = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba  = b_reg - a_reg;
    assign trial    = {rem_reg, quo_reg[W-1]} - {1'b0, g_reg};
    assign out_busy = ovalid_reg && !res.ready;

    // Items are taken only at the load step of the program.
    assign req.ready               = (ctrl.op == fr_pkg::OP_LOAD);
    assign res.valid               = ovalid_reg;
    assign res.reduced_numerator   = onum_reg;
    assign res.reduced_denominator = oden_reg;
    assign res.status              = ost_reg;

    // Jump condition of the current control word.
    always_comb
    begin
        unique case (ctrl.cond)
            fr_pkg::C_NEVER:    cond_hit = 1'b0;
            fr_pkg::C_ALWAYS:   cond_hit = 1'b1;
            fr_pkg::C_NOVALID:  cond_hit = !req.valid;
            fr_pkg::C_SPECIAL:  cond_hit = spec_reg;
            fr_pkg::C_BOTHEVEN: cond_hit = !a_reg[0] && !b_reg[0];
            fr_pkg::C_ANZ:      cond_hit = (a_reg != '0);
            fr_pkg::C_CNTNZ:    cond_hit = (cnt_reg != '0);
            fr_pkg::C_OUTBUSY:  cond_hit = out_busy;
            default:            cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? ctrl.target : step_reg + 1'b1;
    end

    // Datapath: each control word selects one operation.
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        g_next      = g_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        spec_next   = spec_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        st_next     = st_reg;
        onum_next   = onum_reg;
        oden_next   = oden_reg;
        ost_next    = ost_reg;
        ovalid_next = ovalid_reg && !res.ready;

        unique case (ctrl.op)
            fr_pkg::OP_NONE:
            begin
            end
            fr_pkg::OP_LOAD:
            begin
                // Special cases are settled here; the general case sets up the GCD.
                rn_next   = '0;
                rd_next   = '0;
                st_next   = fr_pkg::ST_OK;
                spec_next = 1'b1;
                an_next   = num_in[W-1] ? -num_in : num_in;
                ad_next   = den_in[W-1] ? -den_in : den_in;
                a_next    = num_in[W-1] ? -num_in : num_in;
                b_next    = den_in[W-1] ? -den_in : den_in;
                k_next    = '0;
                neg_next  = num_in[W-1] ^ den_in[W-1];
                priority if (den_in == '0)
                begin
                    st_next = fr_pkg::ST_ZERO_DEN;
                end
                else if (num_in == most_neg || den_in == most_neg)
                begin
                    st_next = fr_pkg::ST_MOST_NEG;
                end
                else if (num_in == '0)
                begin
                    rd_next = den_in;
                end
                else
                begin
                    spec_next = 1'b0;
                end
            end
            fr_pkg::OP_PAIR:
            begin
                // Strip the power of two that both magnitudes share.
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            fr_pkg::OP_GSTEP:
            begin
                if (a_reg != '0)
                begin
                    priority if (!a_reg[0])
                    begin
                        a_next = a_reg >> 1;
                    end
                    else if (!b_reg[0])
                    begin
                        b_next = b_reg >> 1;
                    end
                    else if (!diff_ab[W])
                    begin
                        a_next = diff_ab[W-1:0] >> 1;
                    end
                    else
                    begin
                        b_next = diff_ba >> 1;
                    end
                end
            end
            fr_pkg::OP_GFIN:
            begin
                g_next   = b_reg << k_reg;
                rem_next = '0;
                quo_next = an_reg;
                cnt_next = fr_pkg::CNT_W'(W - 1);
            end
            fr_pkg::OP_DIVSTEP:
            begin
                // One quotient bit a cycle, restoring.
                if (!trial[W])
                begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            fr_pkg::OP_SAVEN:
            begin
                rn_next  = neg_reg ? -quo_reg : quo_reg;
                rem_next = '0;
                quo_next = ad_reg;
                cnt_next = fr_pkg::CNT_W'(W - 1);
            end
            fr_pkg::OP_SAVED:
            begin
                rd_next = quo_reg;
            end
            fr_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    onum_next   = rn_reg;
                    oden_next   = rd_reg;
                    ost_next    = st_reg;
                    ovalid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= fr_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        spec_reg <= spec_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        st_reg   <= st_next;
        onum_reg <= onum_next;
        oden_reg <= oden_next;
        ost_reg  <= ost_next;
    end

endmodule

@@ src/fr_checker.sv @@
// Port-level checks of the fraction reducer, bound to the top level.
// Depends on fr_pkg and fraction_reducer.
module fr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [fr_pkg::DATA_WIDTH-1:0] res_num,
    input logic [fr_pkg::DATA_WIDTH-1:0] res_den,
    input logic [1:0]                    res_status
);

    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == fr_pkg::ST_ZERO_DEN || res_status == fr_pkg::ST_MOST_NEG)
        |-> res_num == '0 && res_den == '0)
        else $error("error result with non-zero fields");

    // A good result never has a zero denominator.
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == fr_pkg::ST_OK |-> res_den != '0)
        else $error("good result with zero denominator");

    // A reduced non-zero fraction has a positive denominator.
    a_ok_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == fr_pkg::ST_OK && res_num != '0
        |-> !res_den[fr_pkg::DATA_WIDTH-1])
        else $error("reduced denominator is negative");

    // A stalled result item holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_num) && $stable(res_den)
        && $stable(res_status))
        else $error("stalled result item changed");

endmodule

bind fraction_reducer fr_checker u_fr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_num    (res.reduced_numerator),
    .res_den    (res.reduced_denominator),
    .res_status (res.status)
);

@@ tb/tb_fraction_reducer.sv @@
// Self-checking testbench for fraction_reducer: directed fractions, then random ones,
// with idling and stalls on both channels. Uses fr_pkg and the fr_in_if / fr_out_if
// interfaces from the source tree.
`timescale 1ns / 1ps

module tb_fraction_reducer;

    localparam int W = fr_pkg::DATA_WIDTH;

    // Items of random stimulus after the directed table.
    localparam int RANDOM_ITEMS = 1130;
    // Item index at which the receiver holds off for a long stretch.
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;
    // Item index at which the sender pauses until every result is back.
    localparam int DRAIN_AT     = 450;
    // Stretch of items during which neither side idles.
    localparam int QUIET_FROM   = 650;
    localparam int QUIET_TO     = 850;
    // Percentage of cycles in which each side idles.
    localparam int IDLE_PCT     = 24;
    // Cycles allowed after the last result, and the overall cycle limit.
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic signed [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    // One reduced fraction, as the block presents it on its result channel.
    typedef struct packed {
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        logic [1:0]          status;
    } fraction_t;

    // One row of the directed table. Where fixed_result is set, the row carries
    // its expected result; otherwise the predictor works it out.
    typedef struct packed {
        logic signed [W-1:0] n;
        logic signed [W-1:0] d;
        logic                fixed_result;
        fraction_t           want;
    } case_row_t;

    localparam int NUM_DIRECTED = 24;

    logic clk;
    logic rst_n;

    fr_in_if  req_ch ();
    fr_out_if res_ch ();

    fraction_reducer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Expected reduced fractions, oldest first, one per accepted item.
    fraction_t pending_fractions [$];

    int  mismatch_count;
    int  results_seen;
    int  cycle_count;
    // Set by the sender to start the long receiver hold; cleared by the receiver.
    bit  hold_request;
    // High while neither side is allowed to idle.
    bit  no_idle;

    case_row_t directed_rows [NUM_DIRECTED];

    // Clock with an 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Reset is held low at the start, then released and never asserted again.
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Predictor: reduces n/d to lowest terms with Euclid's method on the magnitudes.
    // A zero denominator is checked first, so that a zero denominator paired with the
    // most negative numerator reports the zero denominator. A zero numerator leaves
    // the denominator exactly as it came in, sign included.
    function automatic fraction_t reduce_fraction(input logic signed [W-1:0] n,
                                                  input logic signed [W-1:0] d);
        fraction_t         f;
        longint unsigned   mag_n;
        longint unsigned   mag_d;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   r;
        logic [W-1:0]      quot_n;
        logic [W-1:0]      quot_d;
        f = '{num: '0, den: '0, status: fr_pkg::ST_OK};
        if (d == 0)
        begin
            f.status = fr_pkg::ST_ZERO_DEN;
        end
        else if (n == MOST_NEG || d == MOST_NEG)
        begin
            f.status = fr_pkg::ST_MOST_NEG;
        end
        else if (n == 0)
        begin
            f.den = d;
        end
        else
        begin
            // Neither operand is the most negative value here, so negation is safe.
            mag_n = (n < 0) ? longint'(-n) : longint'(n);
            mag_d = (d < 0) ? longint'(-d) : longint'(d);
            a = mag_n;
            b = mag_d;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            quot_n = W'(mag_n / a);
            quot_d = W'(mag_d / a);
            f.den = quot_d;
            f.num = ((n < 0) != (d < 0)) ? -quot_n : quot_n;
        end
        return f;
    endfunction

    // Picks one random fraction. Many draws are well-formed fractions with a shared
    // factor or a power of two in common, so that the GCD and both divisions do real work;
    // the rest are raw 32-bit values, tiny values, zero numerators, near-extreme values and the error cases.
    task automatic draw_fraction(output logic signed [W-1:0] n,
                                 output logic signed [W-1:0] d);
        int unsigned sel;
        int unsigned common;
        sel = $urandom_range(99);
        if (sel < 28)
        begin
            n = $urandom;
            d = $urandom;
        end
        else if (sel < 58)
        begin
            common = $urandom_range(1, 65535);
            n = $urandom_range(1, 32767) * common;
            d = $urandom_range(1, 32767) * common;
        end
        else if (sel < 68)
        begin
            n = $urandom_range(1, 255) << $urandom_range(0, 23);
            d = $urandom_range(1, 255) << $urandom_range(0, 23);
        end
        else if (sel < 76)
        begin
            n = $urandom_range(16);
            d = $urandom_range(16);
        end
        else if (sel < 82)
        begin
            // Zero denominator; the numerator is anything at all.
            n = $urandom;
            d = 0;
        end
        else if (sel < 88)
        begin
            // Most negative value in one operand or in both.
            n = $urandom;
            d = $urandom;
            case ($urandom_range(2))
                0:       n = MOST_NEG;
                1:       d = MOST_NEG;
                default:
                begin
                    n = MOST_NEG;
                    d = MOST_NEG;
                end
            endcase
        end
        else if (sel < 93)
        begin
            n = 0;
            d = $urandom;
        end
        else
        begin
            // Operands near the positive extreme, or equal in magnitude.
            n = MAX_POS - $urandom_range(3);
            d = $urandom_range(1) ? n : MAX_POS - $urandom_range(3);
        end
        // Random signs; none of the values above can overflow when negated,
        // and the most negative value simply stays as it is.
        if ($urandom_range(1) && n != MOST_NEG)
        begin
            n = -n;
        end
        if ($urandom_range(1) && d != MOST_NEG)
        begin
            d = -d;
        end
    endtask

    // Offers one fraction on the request channel and holds it until it is taken.
    // On acceptance its expected result joins the back of the queue. Idle cycles
    // before the offer lower valid; once raised, valid stays high until the handshake.
    task automatic offer_fraction(input logic signed [W-1:0] n,
                                  input logic signed [W-1:0] d,
                                  input logic                fixed_result,
                                  input fraction_t           want);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.numerator   <= n;
        req_ch.denominator <= d;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        pending_fractions.push_back(fixed_result ? want : reduce_fraction(n, d));
    endtask

    // Sender: the directed table first, then the random items, then the wait for
    // the last result and the final verdict.
    initial
    begin
        logic signed [W-1:0] n;
        logic signed [W-1:0] d;

        req_ch.valid       <= 1'b0;
        req_ch.numerator   <= '0;
        req_ch.denominator <= '0;
        hold_request = 1'b0;
        no_idle      = 1'b0;

        // Directed cases. The error cases, the zero numerator and the extremes have
        // their results written out; the rest go through the predictor.
        directed_rows = '{
            // Zero denominator, including with a zero or most negative numerator.
            '{32'sd5,     32'sd0,      1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_ZERO_DEN}},
            '{32'sd0,     32'sd0,      1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_ZERO_DEN}},
            '{MOST_NEG,   32'sd0,      1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_ZERO_DEN}},
            // Most negative value in either operand, even with a zero numerator.
            '{MOST_NEG,   32'sd3,      1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_MOST_NEG}},
            '{32'sd7,     MOST_NEG,    1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_MOST_NEG}},
            '{32'sd0,     MOST_NEG,    1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_MOST_NEG}},
            '{MOST_NEG,   MOST_NEG,    1'b1, '{32'sd0, 32'sd0, fr_pkg::ST_MOST_NEG}},
            // Zero numerator keeps the denominator as given, negative or not.
            '{32'sd0,     32'sd5,      1'b1, '{32'sd0, 32'sd5, fr_pkg::ST_OK}},
            '{32'sd0,     -32'sd7,     1'b1, '{32'sd0, -32'sd7, fr_pkg::ST_OK}},
            '{32'sd0,     MAX_POS,     1'b1, '{32'sd0, MAX_POS, fr_pkg::ST_OK}},
            // Unit and extreme magnitudes with various signs, plus two fixed reductions.
            '{32'sd1,     32'sd1,      1'b1, '{32'sd1, 32'sd1, fr_pkg::ST_OK}},
            '{-32'sd1,    -32'sd1,     1'b1, '{32'sd1, 32'sd1, fr_pkg::ST_OK}},
            '{MAX_POS,    MAX_POS,     1'b1, '{32'sd1, 32'sd1, fr_pkg::ST_OK}},
            '{MAX_POS,    -MAX_POS,    1'b1, '{-32'sd1, 32'sd1, fr_pkg::ST_OK}},
            '{-MAX_POS,   32'sd1,      1'b1, '{-MAX_POS, 32'sd1, fr_pkg::ST_OK}},
            '{32'sd1,     -MAX_POS,    1'b1, '{-32'sd1, MAX_POS, fr_pkg::ST_OK}},
            '{32'sd6,     -32'sd4,     1'b1, '{-32'sd3, 32'sd2, fr_pkg::ST_OK}},
            '{32'sh40000000, 32'sh00100000, 1'b1, '{32'sd1024, 32'sd1, fr_pkg::ST_OK}},
            // Ordinary reductions, checked by the predictor.
            '{32'sd12,    32'sd18,     1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}},
            '{MAX_POS - 32'sd1, 32'sh3FFFFFFF, 1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}},
            // Consecutive Fibonacci numbers: the longest Euclid run at this width.
            '{-32'sd1836311903, 32'sd1134903170, 1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}},
            '{32'sh55555555, -32'sh2AAAAAAA, 1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}},
            '{-32'sd360,  -32'sd84,    1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}},
            '{MAX_POS,    32'sd2,      1'b0, '{32'sd0, 32'sd0, fr_pkg::ST_OK}}
        };

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_fraction(directed_rows[i].n, directed_rows[i].d,
                           directed_rows[i].fixed_result, directed_rows[i].want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Long receiver hold: the sender keeps offering, so the block ends up
            // with a result stuck in its output register and stops taking items.
            if (k == HOLD_AT)
            begin
                hold_request = 1'b1;
            end
            // Sender pause: let the block run completely dry before going on.
            if (k == DRAIN_AT)
            begin
                req_ch.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending_fractions.size() != 0);
            end
            no_idle = (k >= QUIET_FROM && k < QUIET_TO);
            draw_fraction(n, d);
            offer_fraction(n, d, 1'b0, '0);
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        // Wait for the last result, then give the block time to show any spurious one.
        do
        begin
            @(posedge clk);
        end
        while (pending_fractions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: random stalls, no stalls during the quiet stretch, and one long hold
    // whose length is counted here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (no_idle)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result checker: each accepted result is compared field by field with the
    // oldest expectation. The first ten failures are reported in full.
    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_fractions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("result %0d: unexpected item num %0d den %0d status %0d",
                             results_seen, res_ch.reduced_numerator,
                             res_ch.reduced_denominator, res_ch.status);
                end
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (res_ch.reduced_numerator !== want.num
                    || res_ch.reduced_denominator !== want.den
                    || res_ch.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d: expected num %0d den %0d status %0d",
                                 results_seen, want.num, want.den, want.status);
                        $display("result %0d: got      num %0d den %0d status %0d",
                                 results_seen, res_ch.reduced_numerator,
                                 res_ch.reduced_denominator, res_ch.status);
                    end
                end
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_fractions.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        results_seen   = 0;
        cycle_count    = 0;
    end

endmodule
